// ===== rtl/assert_macros.svh =====
// Assertion helpers. Both expect signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define DPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/dpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dpd_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int KIND_COUNT_DEF = 4;

  localparam int POS_W   = 22;
  localparam int VEL_W   = 32;
  localparam int NOISE_W = 21;
  localparam int KIND_W  = 2;
  localparam int FORCE_W = 48;
  localparam int CFG_W   = 60;
  localparam int CFG_IDX_W = 3;
  localparam int WORD_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TLOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TMID  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THIGH = 3'd7;

  localparam logic [22:0] BOX_RST   = 23'd983040;
  localparam logic [24:0] GAMMA_RST = 25'd294912;
  localparam logic [30:0] NOISE_RST = 31'd65536;
  localparam logic [30:0] KS_RST    = 31'd6553600;
  localparam logic [18:0] RS_RST    = 19'd6554;
  localparam logic [CFG_W-1:0] TLOW_RST  = 60'd220224474521625;
  localparam logic [CFG_W-1:0] TMID_RST  = 60'd28202688027238600;
  localparam logic [CFG_W-1:0] THIGH_RST = 60'd1100161324;

  localparam logic [WORD_W-1:0] TERM_CAP = 64'd1 << 60;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] result;
  } mul_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/dpd_mulq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dpd_mulq #(
  parameter int FRAC_BITS = dpd_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dpd_pkg::mul_req_t req,
  output dpd_pkg::mul_rsp_t      rsp
);

  localparam int WW = dpd_pkg::WORD_W;
  localparam int AW = 2 * WW;

  logic [WW-1:0] ma_r, mb_r;
  logic          neg_r;
  logic [AW-1:0] acc_r;
  logic [1:0]    cnt_r;
  logic          busy_r, done_r;
  logic [WW+15:0] prod;
  logic [WW-1:0]  p;
  logic [WW-1:0]  mag_a, mag_b;

  assign mag_a = req.a[WW-1] ? WW'(-req.a) : WW'(req.a);
  assign mag_b = req.b[WW-1] ? WW'(-req.b) : WW'(req.b);
  assign prod  = (WW+16)'(ma_r) * (WW+16)'(mb_r[WW-1 -: 16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == 2'd3);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= mag_a;
      mb_r  <= mag_b;
      neg_r <= req.a[WW-1] ^ req.b[WW-1];
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[AW-17:0], 16'd0} + AW'(prod);
      mb_r  <= {mb_r[WW-17:0], 16'd0};
    end
  end

  always_comb begin
    if (|acc_r[AW-1:WW]) begin
      p = dpd_pkg::TERM_CAP;
    end else if ((acc_r[WW-1:0] >> FRAC_BITS) > dpd_pkg::TERM_CAP) begin
      p = dpd_pkg::TERM_CAP;
    end else begin
      p = acc_r[WW-1:0] >> FRAC_BITS;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = neg_r ? $signed(-p) : $signed(p);

endmodule
`default_nettype wire

// ===== rtl/dpd_pair_force_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accumulates the 2-D DPD pair force on one particle, one neighbor pair per item, and
// emits the saturated force sums with the item that has last_pair set. The block takes
// one item at a time: in_stall is high from acceptance until the pair is summed. An item
// goes through wrapping and squaring, a bit-pair square root, the restoring divider
// (two unit-vector components and the spring ratio), and capped multiplies in the
// shared 64 x 16 digit multiplier: 17 multiplies for a bonded pair inside the cutoff,
// 14 unbonded, 3 bonded outside it, none outside and unbonded. A pair at zero distance
// skips the root, the divider and the multiplies. A finished result waits in the output
// register while the next item is accepted.
`include "assert_macros.svh"
module dpd_pair_force_accumulator #(
  parameter int FRAC_BITS  = dpd_pkg::FRAC_BITS_DEF,
  parameter int KIND_COUNT = dpd_pkg::KIND_COUNT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [dpd_pkg::POS_W-1:0]            in_self_x,
  input  wire logic [dpd_pkg::POS_W-1:0]            in_self_y,
  input  wire logic [dpd_pkg::POS_W-1:0]            in_other_x,
  input  wire logic [dpd_pkg::POS_W-1:0]            in_other_y,
  input  wire logic signed [dpd_pkg::VEL_W-1:0]     in_rel_vel_x,
  input  wire logic signed [dpd_pkg::VEL_W-1:0]     in_rel_vel_y,
  input  wire logic [dpd_pkg::KIND_W-1:0]           in_self_kind,
  input  wire logic [dpd_pkg::KIND_W-1:0]           in_other_kind,
  input  wire logic signed [dpd_pkg::NOISE_W-1:0]   in_noise_sample,
  input  wire logic                                 in_bonded,
  input  wire logic                                 in_last_pair,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dpd_pkg::FORCE_W-1:0]        out_force_x,
  output logic signed [dpd_pkg::FORCE_W-1:0]        out_force_y,
  output logic                                      out_saturated,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [dpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dpd_pkg::CFG_W-1:0]            cfg_data
);

  localparam int WW     = dpd_pkg::WORD_W;
  localparam int FW     = dpd_pkg::FORCE_W;
  localparam int D_W    = 23;
  localparam int M_W    = 22;
  localparam int R2_W   = 46;
  localparam int R_W    = 23;
  localparam int NUM_W  = R_W + FRAC_BITS;
  localparam int S_W    = NUM_W + 1;
  localparam int EX_W   = FRAC_BITS + 2;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int CMP_W  = 26;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;
  localparam logic [2:0] S_SQY  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;

  localparam logic [1:0] DV_EX = 2'd0;
  localparam logic [1:0] DV_EY = 2'd1;
  localparam logic [1:0] DV_SP = 2'd2;

  localparam logic [4:0] M_AC  = 5'd0;
  localparam logic [4:0] M_T1  = 5'd1;
  localparam logic [4:0] M_T2  = 5'd2;
  localparam logic [4:0] M_WW  = 5'd3;
  localparam logic [4:0] M_G   = 5'd4;
  localparam logic [4:0] M_SD  = 5'd5;
  localparam logic [4:0] M_NW  = 5'd6;
  localparam logic [4:0] M_SR  = 5'd7;
  localparam logic [4:0] M_ACX = 5'd8;
  localparam logic [4:0] M_SDX = 5'd9;
  localparam logic [4:0] M_SRX = 5'd10;
  localparam logic [4:0] M_ACY = 5'd11;
  localparam logic [4:0] M_SDY = 5'd12;
  localparam logic [4:0] M_SRY = 5'd13;
  localparam logic [4:0] M_FS  = 5'd14;
  localparam logic [4:0] M_FSX = 5'd15;
  localparam logic [4:0] M_FSY = 5'd16;

  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;
  localparam logic [S_W-1:0]   ONE_S = S_W'(1) << FRAC_BITS;
  localparam logic signed [WW:0] MAX48 = (WW+1)'((65'd1 << (FW-1)) - 65'd1);
  localparam logic signed [WW:0] MIN48 = -MAX48 - (WW+1)'(1);

  function automatic logic signed [D_W-1:0] wrap_d(input logic [M_W-1:0] a,
                                                   input logic [M_W-1:0] b,
                                                   input logic [22:0] len);
    logic signed [CMP_W-1:0] d;
    logic signed [CMP_W-1:0] l;
    logic signed [CMP_W-1:0] res;
    d = $signed(CMP_W'(a)) - $signed(CMP_W'(b));
    l = $signed(CMP_W'(len));
    if ((d <<< 1) > l) begin
      res = d - l;
    end else if ((d <<< 1) <= -l) begin
      res = d + l;
    end else begin
      res = d;
    end
    return D_W'(res);
  endfunction

  logic [2:0]  state_r;
  logic [22:0] box_r;
  logic [24:0] gamma_r;
  logic [30:0] noise_r, ks_r;
  logic [18:0] rs_r;
  logic [dpd_pkg::CFG_W-1:0] tlow_r, tmid_r, thigh_r;

  logic signed [D_W-1:0]  dx_r, dy_r;
  logic signed [dpd_pkg::VEL_W-1:0] dvx_r, dvy_r;
  logic signed [dpd_pkg::NOISE_W-1:0] xi_r;
  logic bonded_r, last_r;
  logic [9:0] coef_r;
  logic [R2_W-1:0] r2_r, rv_r, res_r, bit_r;
  logic [R_W-1:0]  r_r, den_r;
  logic [NUM_W-1:0] num_r;
  logic [R_W-1:0]   rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [1:0] dsel_r;
  logic signed [EX_W-1:0] ex_r, ey_r;
  logic signed [S_W-1:0]  s_r;
  logic [W_W-1:0] w_r;
  logic [4:0] step_r;
  logic mwait_r;
  logic signed [WW-1:0] ac_r, pv_r, wwg_r, sd_r, nsr_r, fs_r, px_r, py_r;
  logic signed [FW-1:0] sum_x_r, sum_y_r;
  logic clip_r;

  logic [M_W-1:0] mx, my;
  logic [179:0] table_w;
  logic [3:0] kidx;
  logic [9:0] coef_nxt;
  logic [R2_W-1:0] sq_y, rb_sum, res_nxt;
  logic [R_W:0] rem_sh;
  logic q_bit;
  logic [NUM_W-1:0] q_fin;
  logic signed [EX_W-1:0] e_nxt;
  logic in_cutoff;
  logic [4:0] first_step, next_step;
  logic [1:0] kind_ok;
  dpd_pkg::mul_req_t mul_req;
  dpd_pkg::mul_rsp_t mul_rsp;
  logic signed [WW:0] sx, sy;
  logic signed [FW-1:0] sx_sat, sy_sat;
  logic clip_x, clip_y;
  logic out_take;

  dpd_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_take = out_valid && !out_stall;

  assign mx = dx_r[D_W-1] ? M_W'(-dx_r) : M_W'(dx_r);
  assign my = dy_r[D_W-1] ? M_W'(-dy_r) : M_W'(dy_r);
  assign sq_y = R2_W'(my) * R2_W'(my);

  assign table_w  = {thigh_r[39:0], tmid_r, tlow_r};
  assign kidx     = {in_self_kind, in_other_kind};
  assign kind_ok[0] = {1'b0, in_self_kind} < 3'(KIND_COUNT);
  assign kind_ok[1] = {1'b0, in_other_kind} < 3'(KIND_COUNT);
  assign coef_nxt = (&kind_ok) ? table_w[8'(kidx) * 8'd10 +: 10] : 10'd0;

  assign rb_sum  = res_r + bit_r;
  assign res_nxt = (rv_r >= rb_sum) ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, den_r};
  assign q_fin  = {num_r[NUM_W-2:0], q_bit};
  assign e_nxt  = EX_W'(q_fin);

  assign in_cutoff = CMP_W'(r_r) <= ONE_C;
  assign first_step = in_cutoff ? M_AC : M_FS;

  always_comb begin
    unique case (step_r)
      M_SRY:   next_step = M_FS;
      default: next_step = step_r + 5'd1;
    endcase
  end

  always_comb begin
    mul_req.start = (state_r == S_MUL) && !mwait_r;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (step_r)
      M_AC:  begin mul_req.a = WW'(coef_r) << FRAC_BITS; mul_req.b = WW'(w_r); end
      M_T1:  begin mul_req.a = WW'(ex_r); mul_req.b = WW'(dvx_r); end
      M_T2:  begin mul_req.a = WW'(ey_r); mul_req.b = WW'(dvy_r); end
      M_WW:  begin mul_req.a = WW'(w_r); mul_req.b = WW'(w_r); end
      M_G:   begin mul_req.a = WW'(gamma_r); mul_req.b = wwg_r; end
      M_SD:  begin mul_req.a = wwg_r; mul_req.b = pv_r; end
      M_NW:  begin mul_req.a = WW'(noise_r); mul_req.b = WW'(w_r); end
      M_SR:  begin mul_req.a = nsr_r; mul_req.b = WW'(xi_r); end
      M_ACX: begin mul_req.a = ac_r; mul_req.b = WW'(ex_r); end
      M_SDX: begin mul_req.a = sd_r; mul_req.b = WW'(ex_r); end
      M_SRX: begin mul_req.a = nsr_r; mul_req.b = WW'(ex_r); end
      M_ACY: begin mul_req.a = ac_r; mul_req.b = WW'(ey_r); end
      M_SDY: begin mul_req.a = sd_r; mul_req.b = WW'(ey_r); end
      M_SRY: begin mul_req.a = nsr_r; mul_req.b = WW'(ey_r); end
      M_FS:  begin mul_req.a = WW'(ks_r); mul_req.b = WW'(s_r); end
      M_FSX: begin mul_req.a = fs_r; mul_req.b = WW'(ex_r); end
      M_FSY: begin mul_req.a = fs_r; mul_req.b = WW'(ey_r); end
      default: begin mul_req.a = '0; mul_req.b = '0; end
    endcase
  end

  assign sx = (WW+1)'(sum_x_r) + (WW+1)'(px_r);
  assign sy = (WW+1)'(sum_y_r) + (WW+1)'(py_r);
  assign clip_x = (sx > MAX48) || (sx < MIN48);
  assign clip_y = (sy > MAX48) || (sy < MIN48);
  assign sx_sat = (sx > MAX48) ? FW'(MAX48) : ((sx < MIN48) ? FW'(MIN48) : FW'(sx));
  assign sy_sat = (sy > MAX48) ? FW'(MAX48) : ((sy < MIN48) ? FW'(MIN48) : FW'(sy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r   <= dpd_pkg::BOX_RST;
      gamma_r <= dpd_pkg::GAMMA_RST;
      noise_r <= dpd_pkg::NOISE_RST;
      ks_r    <= dpd_pkg::KS_RST;
      rs_r    <= dpd_pkg::RS_RST;
      tlow_r  <= dpd_pkg::TLOW_RST;
      tmid_r  <= dpd_pkg::TMID_RST;
      thigh_r <= dpd_pkg::THIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dpd_pkg::CFG_BOX:   box_r   <= cfg_data[22:0];
        dpd_pkg::CFG_GAMMA: gamma_r <= cfg_data[24:0];
        dpd_pkg::CFG_NOISE: noise_r <= cfg_data[30:0];
        dpd_pkg::CFG_KS:    ks_r    <= cfg_data[30:0];
        dpd_pkg::CFG_RS:    rs_r    <= cfg_data[18:0];
        dpd_pkg::CFG_TLOW:  tlow_r  <= cfg_data;
        dpd_pkg::CFG_TMID:  tmid_r  <= cfg_data;
        dpd_pkg::CFG_THIGH: thigh_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mwait_r   <= 1'b0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      clip_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_take && !((state_r == S_ACC) && last_r)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SQX;
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          state_r <= ((r2_r + sq_y) == '0) ? S_ACC : S_ROOT;
        end
        S_ROOT: begin
          if (bit_r[0]) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if ((dcnt_r == DCNT_W'(NUM_W - 1)) && (dsel_r == DV_SP)) begin
            state_r <= (in_cutoff || bonded_r) ? S_MUL : S_ACC;
          end
        end
        S_MUL: begin
          if (!mwait_r) begin
            mwait_r <= 1'b1;
          end else if (mul_rsp.done) begin
            mwait_r <= 1'b0;
            if ((step_r == M_FSY) || ((step_r == M_SRY) && !bonded_r)) begin
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (!(last_r && out_valid && out_stall)) begin
            state_r <= S_IDLE;
            if (last_r) begin
              out_valid <= 1'b1;
              sum_x_r   <= '0;
              sum_y_r   <= '0;
              clip_r    <= 1'b0;
            end else begin
              sum_x_r <= sx_sat;
              sum_y_r <= sy_sat;
              clip_r  <= clip_r | clip_x | clip_y;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        dx_r     <= wrap_d(in_self_x, in_other_x, box_r);
        dy_r     <= wrap_d(in_self_y, in_other_y, box_r);
        dvx_r    <= in_rel_vel_x;
        dvy_r    <= in_rel_vel_y;
        xi_r     <= in_noise_sample;
        bonded_r <= in_bonded;
        last_r   <= in_last_pair;
        coef_r   <= coef_nxt;
        px_r     <= '0;
        py_r     <= '0;
      end
      S_SQX: r2_r <= R2_W'(mx) * R2_W'(mx);
      S_SQY: begin
        rv_r  <= r2_r + sq_y;
        res_r <= '0;
        bit_r <= R2_W'(1) << 44;
      end
      S_ROOT: begin
        if (rv_r >= rb_sum) begin
          rv_r <= rv_r - rb_sum;
        end
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          r_r    <= R_W'(res_nxt);
          den_r  <= R_W'(res_nxt);
          num_r  <= NUM_W'(mx) << FRAC_BITS;
          rem_r  <= '0;
          dcnt_r <= '0;
          dsel_r <= DV_EX;
          w_r    <= W_W'(ONE_C - CMP_W'(res_nxt));
        end
      end
      S_DIV: begin
        if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
          rem_r  <= '0;
          dcnt_r <= '0;
          step_r <= first_step;
          unique case (dsel_r)
            DV_EX: begin
              ex_r   <= dx_r[D_W-1] ? -e_nxt : e_nxt;
              num_r  <= NUM_W'(my) << FRAC_BITS;
              dsel_r <= DV_EY;
            end
            DV_EY: begin
              ey_r   <= dy_r[D_W-1] ? -e_nxt : e_nxt;
              num_r  <= NUM_W'(r_r) << FRAC_BITS;
              den_r  <= (rs_r == '0) ? R_W'(1) : R_W'(rs_r);
              dsel_r <= DV_SP;
            end
            default: begin
              num_r <= q_fin;
              s_r   <= $signed(ONE_S - {1'b0, q_fin});
            end
          endcase
        end else begin
          rem_r  <= q_bit ? R_W'(rem_sh - {1'b0, den_r}) : R_W'(rem_sh);
          num_r  <= q_fin;
          dcnt_r <= dcnt_r + DCNT_W'(1);
        end
      end
      S_MUL: begin
        if (mwait_r && mul_rsp.done) begin
          step_r <= next_step;
          unique case (step_r)
            M_AC:  ac_r  <= mul_rsp.result;
            M_T1:  pv_r  <= mul_rsp.result;
            M_T2:  pv_r  <= pv_r + mul_rsp.result;
            M_WW:  wwg_r <= mul_rsp.result;
            M_G:   wwg_r <= mul_rsp.result;
            M_SD:  sd_r  <= mul_rsp.result;
            M_NW:  nsr_r <= mul_rsp.result;
            M_SR:  nsr_r <= mul_rsp.result;
            M_ACX: px_r  <= mul_rsp.result;
            M_SDX: px_r  <= px_r - mul_rsp.result;
            M_SRX: px_r  <= px_r + mul_rsp.result;
            M_ACY: py_r  <= mul_rsp.result;
            M_SDY: py_r  <= py_r - mul_rsp.result;
            M_SRY: py_r  <= py_r + mul_rsp.result;
            M_FS:  fs_r  <= mul_rsp.result;
            M_FSX: px_r  <= px_r + mul_rsp.result;
            M_FSY: py_r  <= py_r + mul_rsp.result;
            default: ac_r <= ac_r;
          endcase
        end
      end
      S_ACC: begin
        if (last_r && !(out_valid && out_stall)) begin
          out_force_x   <= sx_sat;
          out_force_y   <= sy_sat;
          out_saturated <= clip_r | clip_x | clip_y;
        end
      end
      default: r2_r <= r2_r;
    endcase
  end

  `DPD_ASSERT_IMP(a_mul_start_in_mul, mul_req.start, state_r == S_MUL)
  `DPD_ASSERT_IMP(a_mul_done_awaited, mul_rsp.done, (state_r == S_MUL) && mwait_r)
  `DPD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, state_r != S_IDLE)

endmodule
`default_nettype wire
